// ===== rtl/lesf_pkg.sv =====
// shared types and constants for the largest empty square finder
// no dependencies
package lesf_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int SIZE_W     = 11;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'h2E;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;

  typedef logic [SIZE_W-1:0] sq_size_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef struct packed {
    logic empty;
    col_t col;
    row_t row;
    logic first_row;
    logic row_end;
    logic map_end;
  } cell_ctl_t;

  typedef struct packed {
    sq_size_t size;
    col_t     col;
    row_t     row;
  } square_t;

endpackage

// ===== rtl/lesf_cell_if.sv =====
// input channel carrying one map character per item
// depends on lesf_pkg
interface lesf_cell_if;
  import lesf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  modport source(output valid, output cell_char, input ready);
  modport sink(input valid, input cell_char, output ready);
endinterface

// ===== rtl/lesf_result_if.sv =====
// result channel carrying size and top-left corner of the best square
// depends on lesf_pkg
interface lesf_result_if;
  import lesf_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] square_size;
  logic [COL_W-1:0]  corner_column;
  logic [ROW_W-1:0]  corner_row;
  modport source(output valid, output square_size, output corner_column,
                 output corner_row, input ready);
  modport sink(input valid, input square_size, input corner_column,
               input corner_row, output ready);
endinterface

// ===== rtl/lesf_cfg_if.sv =====
// register write channel: register index and write data
// depends on lesf_pkg
interface lesf_cfg_if;
  import lesf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source(output valid, output reg_index, output wdata, input ready);
  modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/lesf_line_buf.sv =====
// line buffer of previous-row square sizes, registered synchronous read
// forwards a write that lands on the same edge as the read; depends on lesf_pkg
module lesf_line_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  lesf_pkg::col_t   rd_addr,
  input  logic             wr_en,
  input  lesf_pkg::col_t   wr_addr,
  input  lesf_pkg::sq_size_t wr_data,
  output lesf_pkg::sq_size_t rd_data
);
  import lesf_pkg::*;

  sq_size_t mem [MAX_COLUMNS];
  sq_size_t rd_q;
  logic     fwd_hit;
  sq_size_t fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

// ===== rtl/lesf_cell_unit.sv =====
// per-cell stage: min of three neighbors plus one, left/upper-left registers
// and best-square tracking; depends on lesf_pkg
module lesf_cell_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lesf_pkg::cell_ctl_t  ctl_in,
  input  lesf_pkg::sq_size_t   up_mem,
  input  logic                 out_free,
  output logic                 ready,
  output logic                 wr_en,
  output lesf_pkg::col_t       wr_addr,
  output lesf_pkg::sq_size_t   wr_data,
  output logic                 res_load,
  output lesf_pkg::square_t    res
);
  import lesf_pkg::*;

  logic      s1_valid;
  cell_ctl_t ctl;
  sq_size_t  left_size;
  sq_size_t  upper_left_size;
  square_t   best;

  logic        advance;
  sq_size_t    up;
  sq_size_t    m;
  sq_size_t    v;
  logic [SIZE_W:0] col_span;
  logic [SIZE_W:0] row_span;
  logic [SIZE_W:0] v_ext;
  square_t     best_next;

  always_comb begin
    advance = s1_valid && (!ctl.map_end || out_free);
    up      = ctl.first_row ? '0 : up_mem;
    m       = (up < left_size) ? up : left_size;
    m       = (m < upper_left_size) ? m : upper_left_size;
    v       = ctl.empty ? sq_size_t'(m + 1'b1) : '0;
    v_ext    = {1'b0, v};
    col_span = (SIZE_W + 1)'(ctl.col) + 1'b1;
    row_span = (SIZE_W + 1)'(ctl.row) + 1'b1;
    best_next = best;
    if (v > best.size) begin
      best_next.size = v;
      best_next.col  = (col_span >= v_ext) ? col_t'(col_span - v_ext) : '0;
      best_next.row  = (row_span >= v_ext) ? row_t'(row_span - v_ext) : '0;
    end
  end

  assign ready    = !s1_valid || advance;
  assign wr_en    = advance;
  assign wr_addr  = ctl.col;
  assign wr_data  = v;
  assign res_load = advance && ctl.map_end;
  assign res      = best_next;

  always_ff @(posedge clk) begin
    if (load) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      left_size       <= '0;
      upper_left_size <= '0;
      best            <= '0;
    end else begin
      if (ready) begin
        s1_valid <= load;
      end
      if (advance) begin
        left_size       <= ctl.row_end ? '0 : v;
        upper_left_size <= ctl.row_end ? '0 : up;
        best            <= ctl.map_end ? '0 : best_next;
      end
    end
  end

endmodule

// ===== rtl/largest_empty_square_finder.sv =====
// largest empty square finder: raster-order map cells in, one result per map out
// result: the map's last item is registered in the cell stage, then its best square loads the output register once free
// throughput: one item per cycle; input stalls only while a map's last item waits on a held result
// reset: counters, best square and neighbor registers clear, both registers read 1
// the line buffer is not cleared; rows after the first overwrite it before reading
// depends on lesf_pkg, lesf_line_buf, lesf_cell_unit and the channel interfaces
module largest_empty_square_finder (
  input  logic clk,
  input  logic rst,
  lesf_cell_if.sink     cells,
  lesf_result_if.source result,
  lesf_cfg_if.sink      cfg
);
  import lesf_pkg::*;

  logic [CFG_DATA_W-1:0] grid_columns;
  logic [CFG_DATA_W-1:0] grid_rows;
  col_t                  col_count;
  row_t                  row_count;

  logic [SIZE_W-1:0] cols_lim;
  logic [SIZE_W-1:0] rows_lim;
  logic              accept;
  logic              row_end_now;
  logic              map_end_now;
  cell_ctl_t         ctl_in;

  sq_size_t up_mem;
  logic     unit_ready;
  logic     wr_en;
  col_t     wr_addr;
  sq_size_t wr_data;
  logic     res_load;
  square_t  res;
  logic     out_valid;
  square_t  out_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= CFG_DATA_W'(1);
      grid_rows    <= CFG_DATA_W'(1);
    end else if (cfg.valid) begin
      if (cfg.reg_index == CFG_GRID_COLUMNS) begin
        grid_columns <= cfg.wdata;
      end
      if (cfg.reg_index == CFG_GRID_ROWS) begin
        grid_rows <= cfg.wdata;
      end
    end
  end

  always_comb begin
    if (grid_columns == '0) begin
      cols_lim = SIZE_W'(1);
    end else if (grid_columns > SIZE_W'(MAX_COLUMNS)) begin
      cols_lim = SIZE_W'(MAX_COLUMNS);
    end else begin
      cols_lim = grid_columns;
    end
    if (grid_rows == '0) begin
      rows_lim = SIZE_W'(1);
    end else if (grid_rows > SIZE_W'(MAX_ROWS)) begin
      rows_lim = SIZE_W'(MAX_ROWS);
    end else begin
      rows_lim = grid_rows;
    end
    row_end_now = (SIZE_W'(col_count) + 1'b1) >= cols_lim;
    map_end_now = row_end_now && ((SIZE_W'(row_count) + 1'b1) >= rows_lim);
    ctl_in.empty     = (cells.cell_char == EMPTY_CHAR);
    ctl_in.col       = col_count;
    ctl_in.row       = row_count;
    ctl_in.first_row = (row_count == '0);
    ctl_in.row_end   = row_end_now;
    ctl_in.map_end   = map_end_now;
  end

  assign cells.ready = unit_ready;
  assign accept      = cells.valid && unit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end_now) begin
        col_count <= '0;
        row_count <= map_end_now ? '0 : row_t'(row_count + 1'b1);
      end else begin
        col_count <= col_t'(col_count + 1'b1);
      end
    end
  end

  lesf_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_count),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (up_mem)
  );

  lesf_cell_unit u_cell_unit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .ctl_in   (ctl_in),
    .up_mem   (up_mem),
    .out_free (!out_valid || result.ready),
    .ready    (unit_ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.square_size   = out_q.size;
  assign result.corner_column = out_q.col;
  assign result.corner_row    = out_q.row;

  a_map_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && map_end_now |=> (col_count == '0) && (row_count == '0))
    else $error("counters not cleared after last item of map");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    accept && !row_end_now |=> col_count == col_t'($past(col_count) + 1'b1))
    else $error("column counter did not step");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> result.valid && !result.ready)
    else $error("input stalled without a blocked result");

endmodule

// ===== tb/lesf_square_check.sv =====
// checker for the largest empty square finder: follows the cell, result and register
// channels, predicts the best square of each map and compares every result item with it
// depends on lesf_pkg and the cell, result and register channel interfaces
module lesf_square_check (
  input  logic   clk,
  input  logic   rst,
  lesf_cell_if   cells,
  lesf_result_if result,
  lesf_cfg_if    cfg,
  output int     fail_count,
  output int     pending
);
  import lesf_pkg::*;

  logic [CFG_DATA_W-1:0] columns_reg;
  logic [CFG_DATA_W-1:0] rows_reg;
  sq_size_t row_sizes [MAX_COLUMNS];
  sq_size_t left_size;
  sq_size_t diag_size;
  col_t     col_pos;
  row_t     row_pos;
  square_t  best;
  square_t  want;
  square_t  best_squares [$];

  function automatic int clamp_limit(int value, int lim);
    if (value == 0) return 1;
    if (value > lim) return lim;
    return value;
  endfunction

  task automatic fold_cell(input logic [CHAR_W-1:0] ch);
    int cols;
    int rows;
    int col;
    int row;
    int up;
    int size;
    cols = clamp_limit(int'(columns_reg), MAX_COLUMNS);
    rows = clamp_limit(int'(rows_reg), MAX_ROWS);
    col = int'(col_pos);
    row = int'(row_pos);
    up = (row == 0) ? 0 : int'(row_sizes[col]);
    size = 0;
    if (ch == EMPTY_CHAR) begin
      size = (up < int'(left_size)) ? up : int'(left_size);
      if (int'(diag_size) < size) size = int'(diag_size);
      size = int'(sq_size_t'(size + 1));
    end
    row_sizes[col] = sq_size_t'(size);
    diag_size = sq_size_t'(up);
    left_size = sq_size_t'(size);
    // strictly larger only, so ties keep the uppermost, then leftmost corner
    if (size > int'(best.size)) begin
      best.size = sq_size_t'(size);
      best.col = col_t'((col + 1 >= size) ? col + 1 - size : 0);
      best.row = row_t'((row + 1 >= size) ? row + 1 - size : 0);
    end
    if (col + 1 < cols) begin
      col_pos = col_t'(col + 1);
    end else begin
      col_pos = '0;
      left_size = '0;
      diag_size = '0;
      if (row + 1 < rows) begin
        row_pos = row_t'(row + 1);
      end else begin
        best_squares.push_back(best);
        row_pos = '0;
        best = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      columns_reg = 1;
      rows_reg = 1;
      foreach (row_sizes[i]) row_sizes[i] = '0;
      left_size = '0;
      diag_size = '0;
      col_pos = '0;
      row_pos = '0;
      best = '0;
      best_squares.delete();
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (best_squares.size() == 0) begin
          $error("result item with no expectation: size %0d column %0d row %0d",
                 result.square_size, result.corner_column, result.corner_row);
          fail_count++;
        end else begin
          want = best_squares.pop_front();
          if (result.square_size !== want.size) begin
            $error("square_size: expected %0d, got %0d", want.size, result.square_size);
            fail_count++;
          end
          if (result.corner_column !== want.col) begin
            $error("corner_column: expected %0d, got %0d", want.col, result.corner_column);
            fail_count++;
          end
          if (result.corner_row !== want.row) begin
            $error("corner_row: expected %0d, got %0d", want.row, result.corner_row);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          CFG_GRID_COLUMNS: columns_reg = cfg.wdata;
          CFG_GRID_ROWS:    rows_reg = cfg.wdata;
          default: ;
        endcase
      end
      if (cells.valid && cells.ready) fold_cell(cells.cell_char);
    end
    pending = best_squares.size();
  end

endmodule

// ===== tb/largest_empty_square_finder_test.sv =====
// top of the largest empty square finder test: directed maps and random maps with
// random stalls on both sides; lesf_square_check judges
// depends on lesf_pkg, the channel interfaces, the block and lesf_square_check
module largest_empty_square_finder_test;
  import lesf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [CHAR_W-1:0] OBSTACLE_CHAR = 8'h6F;
  localparam int DRAIN = 6;
  localparam int SMALL_ITEMS = 630;
  localparam int MIN_MAPS = 20;
  localparam int TIMEOUT = 20_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int   fail_count;
  int   pending;
  logic [CHAR_W-1:0] plan [$];

  lesf_cell_if   cell_ch ();
  lesf_result_if result_ch ();
  lesf_cfg_if    cfg_ch ();

  largest_empty_square_finder dut (
    .clk    (clk),
    .rst    (rst),
    .cells  (cell_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  lesf_square_check square_check (
    .clk        (clk),
    .rst        (rst),
    .cells      (cell_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 6);
  endfunction

  function automatic logic [CHAR_W-1:0] obstacle();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(255));
    return (c == EMPTY_CHAR) ? OBSTACLE_CHAR : c;
  endfunction

  task automatic push_text(input string rows_text);
    foreach (rows_text[i]) plan.push_back(rows_text[i]);
  endtask

  task automatic send_plan();
    foreach (plan[i]) begin
      @(negedge clk);
      while (idle_now()) begin
        cell_ch.valid <= 1'b0;
        @(negedge clk);
      end
      cell_ch.valid <= 1'b1;
      cell_ch.cell_char <= plan[i];
      do @(posedge clk); while (!cell_ch.ready);
    end
    @(negedge clk);
    cell_ch.valid <= 1'b0;
    plan.delete();
  endtask

  // wait out every expected result, then let the pipeline drain
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    #TIMEOUT;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int cols;
    int rows;
    int hole;
    int sent;
    int maps;
    bit noise;
    cell_ch.valid = 1'b0;
    cell_ch.cell_char = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_GRID_COLUMNS;
    cfg_ch.wdata = '0;
    sent = 0;
    maps = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset give a one-cell map
    push_text(".");
    send_plan();
    settle();

    // zero counts as one; maps with no empty cell
    write_reg(CFG_GRID_COLUMNS, '0);
    write_reg(CFG_GRID_ROWS, '0);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '0);
    plan.push_back(8'h00);
    plan.push_back(8'hFF);
    send_plan();
    settle();

    // borders and equal squares across rows
    write_reg(CFG_GRID_COLUMNS, 11'd3);
    write_reg(CFG_GRID_ROWS, 11'd3);
    push_text(".....o...");
    send_plan();
    settle();

    // shrink both registers in the middle of a map
    write_reg(CFG_GRID_COLUMNS, 11'd4);
    write_reg(CFG_GRID_ROWS, 11'd4);
    push_text("......");
    send_plan();
    settle();
    write_reg(CFG_GRID_COLUMNS, 11'd2);
    write_reg(CFG_GRID_ROWS, 11'd1);
    push_text(".");
    send_plan();
    settle();

    while (sent < SMALL_ITEMS || maps < MIN_MAPS) begin
      cols = ($urandom_range(9) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      rows = ($urandom_range(9) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      calm = (maps >= 12 && maps < 20);
      write_reg(CFG_GRID_COLUMNS,
                (cols == 1 && $urandom_range(1) == 1) ? '0 : CFG_DATA_W'(cols));
      write_reg(CFG_GRID_ROWS,
                (rows == 1 && $urandom_range(1) == 1) ? '0 : CFG_DATA_W'(rows));
      if ($urandom_range(7) == 0)
        write_reg(($urandom_range(1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  CFG_DATA_W'($urandom));
      noise = ($urandom_range(9) == 0);
      hole = $urandom_range(35);
      repeat (cols * rows) begin
        if (noise)
          plan.push_back(CHAR_W'($urandom_range(255)));
        else if ($urandom_range(99) < hole)
          plan.push_back(obstacle());
        else
          plan.push_back(EMPTY_CHAR);
      end
      sent += cols * rows;
      maps++;
      send_plan();
      settle();
    end
    calm = 1'b0;

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
